// ----- src/wrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants of the weighted reservoir sampler
// Sizes, sequencer codes and the table of successive square roots of one half
// used by the power-of-two unit.
// ----------------------------------------------------------------------------
package wrs_pkg;

  localparam int RESERVOIR_DEPTH = 64;
  localparam int ADDR_W = $clog2(RESERVOIR_DEPTH);
  localparam int FILL_W = $clog2(RESERVOIR_DEPTH + 1);
  localparam int CNT_W = 7;
  localparam int LOG_W = 30;       // -log2 result, Q6.24 (at most 2^29)
  localparam int QUO_W = 46;       // quotient and exponent width
  localparam int LOG_FRAC = 24;
  localparam int DIV_BITS = 46;
  localparam logic [47:0] JUMP_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_NL_NORM, S_NL_MUL, S_NL_ACC, S_DIV, S_PW_STEP,
    S_PW_MUL, S_PW_ACC, S_PW_FIN, S_TH_MUL, S_TH_PW, S_S_MUL, S_S_ADD,
    S_WRITE, S_SCAN, S_DISPATCH, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    SP_KNL, SP_KDIV, SP_KPW, SP_MNL, SP_JNL, SP_JDIV, SP_TNL, SP_TPW
  } step_t;

  typedef logic [31:0] root_tab_t [0:LOG_FRAC-1];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    xx = x;
    while (b > xx) b = b >> 2;
    while (b != 0) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tab_t make_roots();
    root_tab_t tab;
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 0; i < LOG_FRAC; i++) begin
      r = isqrt64(r << 32);
      tab[i] = r[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t PW_ROOTS = make_roots();

endpackage
`default_nettype wire

// ----- src/wrs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wrs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/weighted_reservoir_sampler_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_reservoir_sampler_top: weighted reservoir sampler, exponential jumps
// A small sequencer drives one shared multiplier, a bit-serial divider, a
// squaring -log2 unit and a square-root-table power unit over RAM slots.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result word appears
// for exactly one cycle with done high and cannot be held off. A read word
// is answered from one registered RAM read. A sample word that is skipped by
// the running jump is answered from the idle state. For a sample word that is
// stored, every -log2 runs 24 squaring rounds on the shared multiplier after
// up to 31 normalizing shifts, every division produces its 46 quotient bits
// one at a time, every power runs up to 24 multiply rounds, and the minimum
// search walks the key RAM one slot per cycle over the filled slots. A
// replacement adds the lower-bound power and the draw of the new value on top
// of a fill. Busy stays high while a sample word is stored. reservoir_size is
// written through cfg_write/cfg_data by the user only while the block idles;
// the block itself does not enforce this.
module weighted_reservoir_sampler_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic        [6:0]  cfg_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic        [31:0] weight,
  input  wire logic signed [31:0] first_x,
  input  wire logic signed [31:0] first_y,
  input  wire logic signed [31:0] first_z,
  input  wire logic signed [31:0] second_x,
  input  wire logic signed [31:0] second_y,
  input  wire logic signed [31:0] second_z,
  input  wire logic        [31:0] rand_key,
  input  wire logic        [31:0] rand_jump,
  input  wire logic        [5:0]  read_slot,
  output logic                    done,
  output logic                    stored,
  output logic             [5:0]  slot_index,
  output logic             [31:0] slot_key,
  output logic signed      [31:0] out_first_x,
  output logic signed      [31:0] out_first_y,
  output logic signed      [31:0] out_first_z,
  output logic signed      [31:0] out_second_x,
  output logic signed      [31:0] out_second_y,
  output logic signed      [31:0] out_second_z,
  output logic                    slot_valid
);

  localparam int AW = wrs_pkg::ADDR_W;
  localparam int FW = wrs_pkg::FILL_W;
  localparam int CW = wrs_pkg::CNT_W;
  localparam int LW = wrs_pkg::LOG_W;
  localparam int QW = wrs_pkg::QUO_W;

  wrs_pkg::state_t state, state_next;
  wrs_pkg::step_t  step;

  // Architectural state.
  logic [6:0]    res_size;
  logic [FW-1:0] fill_count;
  logic [31:0]   min_key;
  logic [AW-1:0] min_slot;
  logic [47:0]   jump_left;

  // Captured input word.
  logic [31:0] w_q, rk_q, rj_q;
  logic [95:0] vec1, vec2;
  logic [5:0]  rs_q;
  logic        filling;
  logic [AW-1:0] wslot;

  // Unit registers.
  logic [CW-1:0] cnt;
  logic [31:0]   nx, ny;
  logic [4:0]    nn;
  logic [23:0]   nf;
  logic [LW-1:0] lval, lm;
  logic [QW-1:0] dq;
  logic [31:0]   drem, dden;
  logic [QW-1:0] pe;
  logic [32:0]   acc;
  logic [31:0]   pres, tval, key_val;
  logic [65:0]   prod;
  logic [32:0]   mul_a, mul_b;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] raddr;
  logic [31:0]   key_rd;
  logic [95:0]   vec1_rd, vec2_rd;

  // Combinational helpers.
  logic [6:0]  k_eff;
  logic [31:0] w_in;
  logic [32:0] nl_t;
  logic [23:0] nf_new;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [32:0] acc_sh;
  logic [33:0] s_sum;
  logic [31:0] s_val;
  logic        scan_take;
  logic [31:0] mk_new;

  assign busy = (state != wrs_pkg::S_IDLE);

  always_comb begin
    if (res_size == 7'd0) begin
      k_eff = 7'd1;
    end else if (res_size > 7'(wrs_pkg::RESERVOIR_DEPTH)) begin
      k_eff = 7'(wrs_pkg::RESERVOIR_DEPTH);
    end else begin
      k_eff = res_size;
    end
    w_in = (weight == 32'd0) ? 32'd1 : weight;
    nl_t = prod[63:31];
    nf_new = {nf[22:0], nl_t[32]};
    rem_sh = {drem, dq[QW-1]};
    div_ge = (rem_sh >= {1'b0, dden});
    acc_sh = acc >> pe[29:24];
    s_sum = {1'b0, tval} + {1'b0, prod[64:32]};
    s_val = (s_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : s_sum[31:0];
    scan_take = (cnt == CW'(1)) || (key_rd < min_key);
    mk_new = (cnt != '0 && scan_take) ? key_rd : min_key;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      wrs_pkg::S_NL_MUL: begin
        mul_a = {1'b0, ny};
        mul_b = {1'b0, ny};
      end
      wrs_pkg::S_PW_MUL: begin
        mul_a = acc;
        mul_b = {1'b0, wrs_pkg::PW_ROOTS[cnt[4:0]]};
      end
      wrs_pkg::S_TH_MUL: begin
        mul_a = {3'b0, lval};
        mul_b = {1'b0, w_q};
      end
      wrs_pkg::S_S_MUL: begin
        mul_a = {1'b0, rk_q};
        mul_b = wrs_pkg::ONE_Q32 - {1'b0, tval};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control.
  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    raddr = cnt[AW-1:0];
    unique case (state)
      wrs_pkg::S_IDLE: begin
        raddr = read_slot;
        if (start) begin
          if (func) begin
            state_next = wrs_pkg::S_READ;
          end else if (fill_count < k_eff) begin
            state_next = wrs_pkg::S_NL_NORM;
          end else if ({16'b0, w_in} >= jump_left) begin
            state_next = wrs_pkg::S_NL_NORM;
          end
        end
      end
      wrs_pkg::S_READ:    state_next = wrs_pkg::S_IDLE;
      wrs_pkg::S_NL_NORM: if (nx[31]) state_next = wrs_pkg::S_NL_MUL;
      wrs_pkg::S_NL_MUL:  state_next = wrs_pkg::S_NL_ACC;
      wrs_pkg::S_NL_ACC: begin
        state_next = (cnt == CW'(wrs_pkg::LOG_FRAC - 1)) ?
                     wrs_pkg::S_DISPATCH : wrs_pkg::S_NL_MUL;
      end
      wrs_pkg::S_DIV: begin
        if (cnt == CW'(wrs_pkg::DIV_BITS - 1)) state_next = wrs_pkg::S_DISPATCH;
      end
      wrs_pkg::S_PW_STEP: begin
        if (pe[5'(wrs_pkg::LOG_FRAC - 1) - cnt[4:0]]) begin
          state_next = wrs_pkg::S_PW_MUL;
        end else if (cnt == CW'(wrs_pkg::LOG_FRAC - 1)) begin
          state_next = wrs_pkg::S_PW_FIN;
        end
      end
      wrs_pkg::S_PW_MUL:  state_next = wrs_pkg::S_PW_ACC;
      wrs_pkg::S_PW_ACC: begin
        state_next = (cnt == CW'(wrs_pkg::LOG_FRAC - 1)) ?
                     wrs_pkg::S_PW_FIN : wrs_pkg::S_PW_STEP;
      end
      wrs_pkg::S_PW_FIN:  state_next = wrs_pkg::S_DISPATCH;
      wrs_pkg::S_TH_MUL:  state_next = wrs_pkg::S_TH_PW;
      wrs_pkg::S_TH_PW:   state_next = wrs_pkg::S_PW_STEP;
      wrs_pkg::S_S_MUL:   state_next = wrs_pkg::S_S_ADD;
      wrs_pkg::S_S_ADD:   state_next = wrs_pkg::S_NL_NORM;
      wrs_pkg::S_WRITE: begin
        ram_we = 1'b1;
        state_next = wrs_pkg::S_SCAN;
      end
      wrs_pkg::S_SCAN: begin
        if (cnt == CW'(fill_count)) state_next = wrs_pkg::S_NL_NORM;
      end
      wrs_pkg::S_DISPATCH: begin
        unique case (step)
          wrs_pkg::SP_KNL:  state_next = wrs_pkg::S_DIV;
          wrs_pkg::SP_KDIV: state_next = wrs_pkg::S_PW_STEP;
          wrs_pkg::SP_KPW:  state_next = wrs_pkg::S_WRITE;
          wrs_pkg::SP_MNL: begin
            state_next = (lval == '0) ? wrs_pkg::S_FIN : wrs_pkg::S_NL_NORM;
          end
          wrs_pkg::SP_JNL:  state_next = wrs_pkg::S_DIV;
          wrs_pkg::SP_JDIV: state_next = wrs_pkg::S_FIN;
          wrs_pkg::SP_TNL:  state_next = wrs_pkg::S_TH_MUL;
          wrs_pkg::SP_TPW:  state_next = wrs_pkg::S_S_MUL;
          default:          state_next = wrs_pkg::S_IDLE;
        endcase
      end
      wrs_pkg::S_FIN:     state_next = wrs_pkg::S_IDLE;
      default:            state_next = wrs_pkg::S_IDLE;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_size   <= 7'd64;
      fill_count <= '0;
      min_key    <= '0;
      min_slot   <= '0;
      jump_left  <= '0;
      done       <= 1'b0;
      step       <= wrs_pkg::SP_KNL;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        res_size <= cfg_data;
      end
      case (state)
        wrs_pkg::S_IDLE: begin
          if (start) begin
            w_q  <= w_in;
            rk_q <= rand_key;
            rj_q <= rand_jump;
            vec1 <= {first_z, first_y, first_x};
            vec2 <= {second_z, second_y, second_x};
            rs_q <= read_slot;
            nn   <= '0;
            nf   <= '0;
            cnt  <= '0;
            if (!func) begin
              if (fill_count < k_eff) begin
                filling <= 1'b1;
                wslot   <= fill_count[AW-1:0];
                step    <= wrs_pkg::SP_KNL;
                nx      <= (rand_key == 32'd0) ? 32'd1 : rand_key;
              end else if ({16'b0, w_in} < jump_left) begin
                // Skipped sample: only the jump moves.
                jump_left    <= jump_left - {16'b0, w_in};
                done         <= 1'b1;
                stored       <= 1'b0;
                slot_index   <= '0;
                slot_key     <= '0;
                slot_valid   <= 1'b0;
                out_first_x  <= '0;
                out_first_y  <= '0;
                out_first_z  <= '0;
                out_second_x <= '0;
                out_second_y <= '0;
                out_second_z <= '0;
              end else begin
                filling <= 1'b0;
                wslot   <= min_slot;
                step    <= wrs_pkg::SP_TNL;
                nx      <= (min_key == 32'd0) ? 32'd1 : min_key;
              end
            end
          end
        end
        wrs_pkg::S_READ: begin
          done       <= 1'b1;
          stored     <= 1'b0;
          slot_index <= rs_q;
          if (FW'(rs_q) < fill_count) begin
            slot_valid   <= 1'b1;
            slot_key     <= key_rd;
            out_first_x  <= vec1_rd[31:0];
            out_first_y  <= vec1_rd[63:32];
            out_first_z  <= vec1_rd[95:64];
            out_second_x <= vec2_rd[31:0];
            out_second_y <= vec2_rd[63:32];
            out_second_z <= vec2_rd[95:64];
          end else begin
            slot_valid   <= 1'b0;
            slot_key     <= '0;
            out_first_x  <= '0;
            out_first_y  <= '0;
            out_first_z  <= '0;
            out_second_x <= '0;
            out_second_y <= '0;
            out_second_z <= '0;
          end
        end
        wrs_pkg::S_NL_NORM: begin
          if (nx[31]) begin
            ny <= nx;
          end else begin
            nx <= {nx[30:0], 1'b0};
            nn <= nn + 5'd1;
          end
        end
        wrs_pkg::S_NL_ACC: begin
          ny  <= nl_t[32] ? nl_t[32:1] : nl_t[31:0];
          nf  <= nf_new;
          cnt <= cnt + CW'(1);
          lval <= {6'(nn) + 6'd1, 24'b0} - {6'b0, nf_new};
        end
        wrs_pkg::S_DIV: begin
          drem <= div_ge ? 32'(rem_sh - {1'b0, dden}) : rem_sh[31:0];
          dq   <= {dq[QW-2:0], div_ge};
          cnt  <= cnt + CW'(1);
        end
        wrs_pkg::S_PW_STEP: begin
          if (!pe[5'(wrs_pkg::LOG_FRAC - 1) - cnt[4:0]]) cnt <= cnt + CW'(1);
        end
        wrs_pkg::S_PW_ACC: begin
          acc <= prod[64:32];
          cnt <= cnt + CW'(1);
        end
        wrs_pkg::S_PW_FIN: begin
          if (pe[QW-1:24] > 22'd32) begin
            pres <= '0;
          end else begin
            pres <= acc_sh[32] ? 32'hFFFF_FFFF : acc_sh[31:0];
          end
        end
        wrs_pkg::S_TH_PW: begin
          pe   <= prod[61:16];
          acc  <= wrs_pkg::ONE_Q32;
          cnt  <= '0;
          step <= wrs_pkg::SP_TPW;
        end
        wrs_pkg::S_S_ADD: begin
          nx   <= (s_val == 32'd0) ? 32'd1 : s_val;
          nn   <= '0;
          nf   <= '0;
          cnt  <= '0;
          step <= wrs_pkg::SP_KNL;
        end
        wrs_pkg::S_WRITE: begin
          if (filling) fill_count <= fill_count + FW'(1);
          cnt <= '0;
        end
        wrs_pkg::S_SCAN: begin
          if (cnt != '0 && scan_take) begin
            min_key  <= key_rd;
            min_slot <= AW'(cnt - CW'(1));
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(fill_count)) begin
            nx   <= (mk_new == 32'd0) ? 32'd1 : mk_new;
            nn   <= '0;
            nf   <= '0;
            cnt  <= '0;
            step <= wrs_pkg::SP_MNL;
          end
        end
        wrs_pkg::S_DISPATCH: begin
          cnt <= '0;
          case (step)
            wrs_pkg::SP_KNL: begin
              dq   <= {lval, 16'b0};
              drem <= '0;
              dden <= w_q;
              step <= wrs_pkg::SP_KDIV;
            end
            wrs_pkg::SP_KDIV: begin
              pe   <= dq;
              acc  <= wrs_pkg::ONE_Q32;
              step <= wrs_pkg::SP_KPW;
            end
            wrs_pkg::SP_KPW: begin
              key_val <= pres;
            end
            wrs_pkg::SP_MNL: begin
              lm <= lval;
              if (lval == '0) begin
                // A key of one gives no finite jump.
                jump_left <= wrs_pkg::JUMP_MAX;
              end else begin
                nx   <= (rj_q == 32'd0) ? 32'd1 : rj_q;
                nn   <= '0;
                nf   <= '0;
                step <= wrs_pkg::SP_JNL;
              end
            end
            wrs_pkg::SP_JNL: begin
              dq   <= {lval, 16'b0};
              drem <= '0;
              dden <= {2'b0, lm};
              step <= wrs_pkg::SP_JDIV;
            end
            wrs_pkg::SP_JDIV: begin
              jump_left <= {2'b0, dq};
            end
            wrs_pkg::SP_TPW: begin
              tval <= pres;
            end
            default: begin
              step <= step;
            end
          endcase
        end
        wrs_pkg::S_FIN: begin
          done         <= 1'b1;
          stored       <= 1'b1;
          slot_index   <= wslot;
          slot_key     <= key_val;
          slot_valid   <= 1'b1;
          out_first_x  <= '0;
          out_first_y  <= '0;
          out_first_z  <= '0;
          out_second_x <= '0;
          out_second_y <= '0;
          out_second_z <= '0;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  wrs_ram #(.WIDTH(32), .DEPTH(wrs_pkg::RESERVOIR_DEPTH)) u_key_ram (
    .clk(clk), .we(ram_we), .waddr(wslot), .wdata(key_val),
    .raddr(raddr), .rdata(key_rd)
  );

  wrs_ram #(.WIDTH(96), .DEPTH(wrs_pkg::RESERVOIR_DEPTH)) u_vec1_ram (
    .clk(clk), .we(ram_we), .waddr(wslot), .wdata(vec1),
    .raddr(raddr), .rdata(vec1_rd)
  );

  wrs_ram #(.WIDTH(96), .DEPTH(wrs_pkg::RESERVOIR_DEPTH)) u_vec2_ram (
    .clk(clk), .we(ram_we), .waddr(wslot), .wdata(vec2),
    .raddr(raddr), .rdata(vec2_rd)
  );

  // A result word only follows work that was under way or a word just taken.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result word without preceding work");

  // The fill count never passes the number of slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(wrs_pkg::RESERVOIR_DEPTH))
    else $error("fill count beyond reservoir depth");

  // A stored sample always reports a valid slot.
  a_stored_valid: assert property (@(posedge clk) disable iff (rst)
    (done && stored) |-> slot_valid)
    else $error("stored word without valid slot");

  // When idle with filled slots, the minimum slot is one of them.
  a_min_in_range: assert property (@(posedge clk) disable iff (rst)
    (!busy && fill_count != '0) |-> (FW'(min_slot) < fill_count))
    else $error("minimum slot outside the filled range");

endmodule
`default_nettype wire
